>>> design/twcr_pkg.sv
// ----------------------------------------------------------------------------
// twcr_pkg
// Shared types and codes for the textured wall column renderer.
// ----------------------------------------------------------------------------
package twcr_pkg;

  // Item modes carried on the input channel.
  localparam logic [1:0] MODE_TEXEL  = 2'd0;
  localparam logic [1:0] MODE_COLUMN = 2'd1;
  localparam logic [1:0] MODE_ROW    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_POS_X      = 3'd0;
  localparam logic [2:0] CFG_POS_Y      = 3'd1;
  localparam logic [2:0] CFG_SCREEN_H   = 3'd2;
  localparam logic [2:0] CFG_CEIL_COLOR = 3'd3;
  localparam logic [2:0] CFG_FLOOR_COLOR = 3'd4;

  localparam logic [11:0] SCREEN_H_RESET = 12'd480;
  localparam logic [11:0] MAX_ROWS       = 12'd2048;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tex_wr;
    logic col_start;
    logic hit_load;
    logic pos_load;
    logic row_take;
    logic out_load;
  } twcr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic col_active;
    logic div_done;
  } twcr_status_t;

endpackage

>>> design/textured_wall_column_renderer_unit.sv
// A row word's texel read and pending fields are registered when the word is accepted;
// the row state then loads the output word register, and no new word is taken until then.
// Texel loads are written as they are accepted. A column start runs through the hit and
// divide states, the latter waiting on the one-bit-per-cycle step divider.
// Reset (synchronous, rst_n low) clears the controller, the column-active flag
// and the configuration registers; texture memory contents are kept.
// ----------------------------------------------------------------------------
// textured_wall_column_renderer_unit
// Top level: raycaster wall column renderer with texture memory.
// ----------------------------------------------------------------------------
module textured_wall_column_renderer_unit import twcr_pkg::*; #(
  parameter int TEX_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [13:0] in_texel_index,
  input  logic [23:0] in_texel_color,
  input  logic        in_side,
  input  logic signed [15:0] in_ray_dir_x,
  input  logic signed [15:0] in_ray_dir_y,
  input  logic [21:0] in_perp_dist,
  input  logic [10:0] in_draw_start,
  input  logic [11:0] in_draw_end,
  input  logic [15:0] in_line_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_pixel_color,
  output logic [10:0] out_row,
  output logic        out_last
);

  twcr_cmd_t    cmd;
  twcr_status_t status;

  twcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  twcr_datapath #(.TEX_SIZE(TEX_SIZE)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_texel_index  (in_texel_index),
    .in_texel_color  (in_texel_color),
    .in_side         (in_side),
    .in_ray_dir_x    (in_ray_dir_x),
    .in_ray_dir_y    (in_ray_dir_y),
    .in_perp_dist    (in_perp_dist),
    .in_draw_start   (in_draw_start),
    .in_draw_end     (in_draw_end),
    .in_line_height  (in_line_height),
    .out_pixel_color (out_pixel_color),
    .out_row         (out_row),
    .out_last        (out_last)
  );

endmodule

>>> design/twcr_div.sv
// ----------------------------------------------------------------------------
// twcr_div
// Restoring divider that forms the texture step, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twcr_div import twcr_pkg::*; #(
  parameter int DW = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [16:0]   trial;
  logic          ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, q_r[DW-1]};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? 16'(trial - {1'b0, d_r}) : trial[15:0];
    q_nxt   = {q_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

>>> design/twcr_datapath.sv
// ----------------------------------------------------------------------------
// twcr_datapath
// Configuration registers, texture memory, column setup and row pixel path.
// ----------------------------------------------------------------------------
module twcr_datapath import twcr_pkg::*; #(
  parameter int TEX_SIZE = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  twcr_cmd_t    cmd,
  output twcr_status_t status,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata,
  input  logic [13:0]  in_texel_index,
  input  logic [23:0]  in_texel_color,
  input  logic         in_side,
  input  logic signed [15:0] in_ray_dir_x,
  input  logic signed [15:0] in_ray_dir_y,
  input  logic [21:0]  in_perp_dist,
  input  logic [10:0]  in_draw_start,
  input  logic [11:0]  in_draw_end,
  input  logic [15:0]  in_line_height,
  output logic [23:0]  out_pixel_color,
  output logic [10:0]  out_row,
  output logic         out_last
);

  localparam int TW    = $clog2(TEX_SIZE);
  localparam int AW    = 2 + 2 * TW;
  localparam int DEPTH = 4 * TEX_SIZE * TEX_SIZE;
  localparam int DW    = TW + 17;

  // Configuration registers.
  logic [21:0] pos_x_r, pos_y_r;
  logic [11:0] screen_h_r;
  logic [23:0] ceil_color_r, floor_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      screen_h_r    <= SCREEN_H_RESET;
      ceil_color_r  <= '0;
      floor_color_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_X:       pos_x_r       <= cfg_wdata[21:0];
        CFG_POS_Y:       pos_y_r       <= cfg_wdata[21:0];
        CFG_SCREEN_H:    screen_h_r    <= cfg_wdata[11:0];
        CFG_CEIL_COLOR:  ceil_color_r  <= cfg_wdata;
        CFG_FLOOR_COLOR: floor_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective screen height, clamped to one through the maximum row count.
  logic [11:0] eff_h;
  always_comb begin
    if (screen_h_r == '0)         eff_h = 12'd1;
    else if (screen_h_r > MAX_ROWS) eff_h = MAX_ROWS;
    else                          eff_h = screen_h_r;
  end

  // Texture memory: one write port for texel loads, one registered read.
  logic [23:0]   mem [DEPTH];
  logic [23:0]   mem_q;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.tex_wr) begin
      mem[AW'(in_texel_index)] <= in_texel_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_take) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Column setup, first step: texture choice and wall hit product.
  logic [15:0]  lh_eff;
  logic signed [38:0] hit_prod;
  logic [1:0]   choice_r;
  logic [23:0]  prod_r;
  logic [11:0]  pos_frac_r;
  logic         mirror_r;
  logic [10:0]  wall_start_r;
  logic [11:0]  wall_end_r;
  logic [15:0]  lh_r;
  logic [TW-1:0] tex_col_r;

  assign lh_eff   = (in_line_height == '0) ? 16'd1 : in_line_height;
  assign hit_prod = $signed({1'b0, in_perp_dist}) *
                    (in_side ? in_ray_dir_x : in_ray_dir_y);

  always_ff @(posedge clk) begin
    if (cmd.col_start) begin
      if (in_side) choice_r <= in_ray_dir_y[15] ? 2'd0 : 2'd1;
      else         choice_r <= in_ray_dir_x[15] ? 2'd2 : 2'd3;
      prod_r       <= hit_prod[23:0];
      pos_frac_r   <= in_side ? pos_x_r[11:0] : pos_y_r[11:0];
      mirror_r     <= in_side ? in_ray_dir_y[15]
                              : (!in_ray_dir_x[15] && (in_ray_dir_x != '0));
      wall_start_r <= in_draw_start;
      wall_end_r   <= in_draw_end;
      lh_r         <= lh_eff;
    end
  end

  // Column setup, second step: texture column from the hit fraction.
  logic [23:0]   frac24;
  logic [TW-1:0] tx;
  assign frac24 = prod_r + {pos_frac_r, 12'd0};
  assign tx     = frac24[23 -: TW];

  always_ff @(posedge clk) begin
    if (cmd.hit_load) begin
      tex_col_r <= mirror_r ? ~tx : tx;
    end
  end

  // Texture step from the step divider.
  logic [DW-1:0] step_q;
  logic          div_done;
  twcr_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.col_start),
    .dividend (DW'(TEX_SIZE) << 16),
    .divisor  (lh_eff),
    .quotient (step_q),
    .done     (div_done)
  );

  // Start position: (draw start - height/2 + line height/2) * step.
  logic signed [17:0]    base;
  logic signed [DW:0]    step_s;
  logic signed [DW+18:0] start_prod;
  logic [31:0]           tex_pos_r;
  logic [31:0]           tex_step_r;

  assign base       = $signed({7'd0, wall_start_r}) - $signed({7'd0, eff_h[11:1]})
                    + $signed({3'd0, lh_r[15:1]});
  assign step_s     = $signed({1'b0, step_q});
  assign start_prod = base * step_s;

  // Row bookkeeping.
  logic [10:0] row_r;
  logic        active_r;
  logic        is_ceil, is_wall, row_last;
  logic [11:0] row_inc;

  assign row_inc  = {1'b0, row_r} + 12'd1;
  assign row_last = (row_inc >= eff_h);
  assign is_ceil  = (row_r < wall_start_r);
  assign is_wall  = !is_ceil && ({1'b0, row_r} < wall_end_r);
  assign rd_addr  = {choice_r, tex_pos_r[16 +: TW], tex_col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
    end else if (cmd.col_start) begin
      active_r <= 1'b1;
      row_r    <= '0;
    end else if (cmd.row_take) begin
      active_r <= !row_last;
      row_r    <= row_last ? 11'd0 : row_inc[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_load) begin
      tex_pos_r  <= start_prod[31:0];
      tex_step_r <= 32'(step_q);
    end else if (cmd.row_take && is_wall) begin
      tex_pos_r <= tex_pos_r + tex_step_r;
    end
  end

  // Pending row word while the texel read completes.
  logic        pend_wall_r;
  logic [23:0] pend_color_r;
  logic [10:0] pend_row_r;
  logic        pend_last_r;

  always_ff @(posedge clk) begin
    if (cmd.row_take) begin
      pend_wall_r  <= is_wall;
      pend_color_r <= is_ceil ? ceil_color_r : floor_color_r;
      pend_row_r   <= row_r;
      pend_last_r  <= row_last;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_color <= pend_wall_r ? mem_q : pend_color_r;
      out_row         <= pend_row_r;
      out_last        <= pend_last_r;
    end
  end

  assign status = '{col_active: active_r, div_done: div_done};

endmodule

>>> design/twcr_ctrl.sv
// ----------------------------------------------------------------------------
// twcr_ctrl
// Controller that sequences column setup and row words.
// ----------------------------------------------------------------------------
module twcr_ctrl import twcr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_mode,
  output logic         out_valid,
  input  logic         out_ready,
  input  twcr_status_t status,
  output twcr_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_HIT, S_DIVW, S_ROW} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   accept;

  // Take a word only when idle and the output register is free next cycle.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.tex_wr    = accept && (in_mode == MODE_TEXEL);
    cmd.col_start = accept && (in_mode == MODE_COLUMN);
    cmd.row_take  = accept && (in_mode == MODE_ROW) && status.col_active;
    cmd.hit_load  = (state_r == S_HIT);
    cmd.pos_load  = (state_r == S_DIVW) && status.div_done;
    cmd.out_load  = (state_r == S_ROW);

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.col_start)     state_nxt = S_HIT;
        else if (cmd.row_take) state_nxt = S_ROW;
      end
      S_HIT:  state_nxt = S_DIVW;
      S_DIVW: if (status.div_done) state_nxt = S_IDLE;
      S_ROW:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ROW) out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/twcr_checker.sv
// ----------------------------------------------------------------------------
// twcr_checker
// Port-level checks for the wall column renderer, bound to the top level.
// ----------------------------------------------------------------------------
module twcr_checker import twcr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_pixel_color,
  input logic [10:0] out_row,
  input logic        out_last
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_color) &&
    $stable(out_row) && $stable(out_last))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Column setup keeps the input closed on the following cycle.
  a_col_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_COLUMN) |=> !in_ready)
    else $error("input open during column setup");

  // A word is taken only when the output register is free or draining.
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken while output word stalled");

endmodule

bind textured_wall_column_renderer_unit twcr_checker u_twcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_color (out_pixel_color),
  .out_row         (out_row),
  .out_last        (out_last)
);

>>> sim/tb_textured_wall_column_renderer_unit.sv
// ----------------------------------------------------------------------------
// Testbench for textured_wall_column_renderer_unit
// Sends texel loads, column starts and row words over the input channel and
// checks every pixel word on the result channel against a predicted column,
// across several register settings and several patterns of idling and stalls.
// ----------------------------------------------------------------------------
module tb_textured_wall_column_renderer_unit import twcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEX_DIM = 64;
  localparam int TEX_WORDS = 4 * TEX_DIM * TEX_DIM;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [1:0]         mode;
    logic [13:0]        texel_index;
    logic [23:0]        texel_color;
    logic               side;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic [21:0]        perp_dist;
    logic [10:0]        draw_start;
    logic [11:0]        draw_end;
    logic [15:0]        line_height;
  } word_t;

  typedef struct {
    logic [23:0] pixel_color;
    logic [10:0] row;
    logic        last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [13:0] in_texel_index = '0;
  logic [23:0] in_texel_color = '0;
  logic in_side = 1'b0;
  logic signed [15:0] in_ray_dir_x = '0;
  logic signed [15:0] in_ray_dir_y = '0;
  logic [21:0] in_perp_dist = '0;
  logic [10:0] in_draw_start = '0;
  logic [11:0] in_draw_end = '0;
  logic [15:0] in_line_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] out_pixel_color;
  logic [10:0] out_row;
  logic out_last;

  textured_wall_column_renderer_unit dut (.*);

  // Words waiting to be sent and pixels still owed by the block.
  word_t  send_q[$];
  pixel_t pixel_expect_q[$];
  int     fail_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 1'b0;
  bit     in_took = 1'b0;
  longint cycle_count = 0;

  // Predicted register and column state.
  logic [23:0] tex_mem [TEX_WORDS];
  bit          tex_written [TEX_WORDS];
  logic [21:0] view_x, view_y;
  logic [11:0] rows_reg;
  logic [23:0] ceil_rgb, floor_rgb;
  logic [1:0]  tex_pick;
  logic [5:0]  tex_col;
  logic [31:0] tex_pos, tex_step;
  logic [10:0] wall_top;
  logic [11:0] wall_bottom;
  logic [10:0] cur_row;
  bit          col_live;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned rows_per_column();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  // Texture word the current row of the wall slice reads.
  function automatic int unsigned wall_texel_addr();
    return tex_pick * TEX_DIM * TEX_DIM + tex_pos[21:16] * TEX_DIM + tex_col;
  endfunction

  function automatic void begin_column(word_t w);
    longint hit;
    longint base;
    logic [5:0] tx;
    int unsigned lh;
    if (w.side && w.ray_dir_y < 0) tex_pick = 2'd0;
    else if (w.side) tex_pick = 2'd1;
    else if (w.ray_dir_x < 0) tex_pick = 2'd2;
    else tex_pick = 2'd3;
    if (!w.side) hit = (longint'(view_y) << 12) + longint'(w.perp_dist) * longint'(w.ray_dir_y);
    else hit = (longint'(view_x) << 12) + longint'(w.perp_dist) * longint'(w.ray_dir_x);
    tx = hit[23:18];
    // Two faces are mirrored so textures read the same way from both sides.
    if ((!w.side && w.ray_dir_x > 0) || (w.side && w.ray_dir_y < 0)) tx = 6'd63 - tx;
    tex_col = tx;
    lh = (w.line_height == 0) ? 1 : w.line_height;
    tex_step = 32'h0040_0000 / lh;
    wall_top = w.draw_start;
    wall_bottom = w.draw_end;
    base = longint'(w.draw_start) - longint'(rows_per_column() / 2) + longint'(lh / 2);
    tex_pos = 32'(base * longint'(tex_step));
    cur_row = '0;
    col_live = 1'b1;
  endfunction

  // Apply one word to the predicted state; returns 1 when a pixel follows.
  function automatic bit predict_pixel(word_t w, output pixel_t px);
    int unsigned r;
    px = '{default: '0};
    case (w.mode)
      MODE_TEXEL: begin
        tex_mem[w.texel_index] = w.texel_color;
        tex_written[w.texel_index] = 1'b1;
        return 1'b0;
      end
      MODE_COLUMN: begin
        begin_column(w);
        return 1'b0;
      end
      MODE_ROW: begin
        if (!col_live) return 1'b0;
        r = cur_row;
        if (r < wall_top) px.pixel_color = ceil_rgb;
        else if (r < wall_bottom) begin
          px.pixel_color = tex_mem[wall_texel_addr()];
          tex_pos = tex_pos + tex_step;
        end else px.pixel_color = floor_rgb;
        px.row = r[10:0];
        px.last = (r + 1 >= rows_per_column());
        if (px.last) begin
          col_live = 1'b0;
          cur_row = '0;
        end else cur_row = r[10:0] + 11'd1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Queue a word; a row that would read an unwritten texel gets a load first.
  task automatic issue(word_t w);
    word_t ld;
    pixel_t px;
    int unsigned addr;
    if (w.mode == MODE_ROW && col_live && cur_row >= wall_top && cur_row < wall_bottom) begin
      addr = wall_texel_addr();
      if (!tex_written[addr]) begin
        ld = '{default: '0};
        ld.mode = MODE_TEXEL;
        ld.texel_index = addr[13:0];
        ld.texel_color = 24'($urandom());
        issue(ld);
      end
    end
    if (predict_pixel(w, px)) pixel_expect_q.push_back(px);
    send_q.push_back(w);
  endtask

  task automatic issue_column(bit side, logic [15:0] dx, logic [15:0] dy, logic [21:0] hit_dist,
                              logic [10:0] ds, logic [11:0] de, logic [15:0] lh);
    word_t w;
    w = '{default: '0};
    w.mode = MODE_COLUMN;
    w.side = side;
    w.ray_dir_x = dx;
    w.ray_dir_y = dy;
    w.perp_dist = hit_dist;
    w.draw_start = ds;
    w.draw_end = de;
    w.line_height = lh;
    w.texel_index = 14'($urandom());
    w.texel_color = 24'($urandom());
    issue(w);
  endtask

  task automatic issue_rows(int n);
    word_t w;
    repeat (n) begin
      w.mode = MODE_ROW;
      w.texel_index = 14'($urandom());
      w.texel_color = 24'($urandom());
      w.side = 1'($urandom());
      w.ray_dir_x = 16'($urandom());
      w.ray_dir_y = 16'($urandom());
      w.perp_dist = 22'($urandom());
      w.draw_start = 11'($urandom());
      w.draw_end = 12'($urandom());
      w.line_height = 16'($urandom());
      issue(w);
    end
  endtask

  task automatic issue_noise();
    word_t w;
    w.mode = 2'($urandom_range(0, 3));
    w.texel_index = 14'($urandom());
    w.texel_color = 24'($urandom());
    w.side = 1'($urandom());
    w.ray_dir_x = 16'($urandom());
    w.ray_dir_y = 16'($urandom());
    w.perp_dist = 22'($urandom());
    w.draw_start = 11'($urandom());
    w.draw_end = 12'($urandom_range(0, 2048));
    w.line_height = 16'($urandom());
    issue(w);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POS_X:       view_x = val[21:0];
      CFG_POS_Y:       view_y = val[21:0];
      CFG_SCREEN_H:    rows_reg = val[11:0];
      CFG_CEIL_COLOR:  ceil_rgb = val;
      CFG_FLOOR_COLOR: floor_rgb = val;
      default: ;
    endcase
  endtask

  // Wait until every word is taken and every pixel has come back.
  task automatic drain();
    while (send_q.size() != 0 || pixel_expect_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Random columns, each a column start and its rows, mixed with random words; the phase may end mid-column.
  task automatic random_phase(int words);
    int sent;
    int h;
    int top;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(99) < 20) begin
        issue_noise();
        sent++;
      end else begin
        h = rows_per_column();
        top = (h > 2047) ? 2047 : h;
        issue_column(1'($urandom()), 16'($urandom()), 16'($urandom()), 22'($urandom()),
                     11'(($urandom_range(9) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, top)),
                     12'(($urandom_range(9) == 0) ? $urandom_range(0, 2048)
                                                  : $urandom_range(0, h)),
                     16'(($urandom_range(3) == 0) ? $urandom()
                                                  : $urandom_range(0, 2 * h + 8)));
        sent++;
        for (int i = 0; i < h && sent < words; i++) begin
          if ($urandom_range(99) < 5) begin
            issue_noise();
            sent++;
          end
          issue_rows(1);
          sent++;
        end
      end
    end
  endtask

  // Stimulus and register phases.
  initial begin
    int idle_send [4] = '{0, 55, 0, 25};
    int idle_recv [4] = '{0, 0, 55, 25};
    int heights [8] = '{1, 0, 13, 30, 5, 4095, 21, 9};
    int lengths [8] = '{130, 130, 200, 200, 200, 100, 200, 200};
    for (int i = 0; i < TEX_WORDS; i++) tex_written[i] = 1'b0;
    view_x = '0;
    view_y = '0;
    rows_reg = SCREEN_H_RESET;
    ceil_rgb = '0;
    floor_rgb = '0;
    col_live = 1'b0;
    cur_row = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_POS_X, 24'h3F_FFFF);
    write_reg(CFG_POS_Y, 24'h00_0000);
    write_reg(CFG_SCREEN_H, 24'd4);
    write_reg(CFG_CEIL_COLOR, 24'hFF_FFFF);
    write_reg(CFG_FLOOR_COLOR, 24'h00_0000);

    // Directed: ignored words, extreme fields, restart and odd wall slices.
    send_q.push_back('{mode: 2'd3, default: '0});
    issue_rows(1);
    issue('{mode: MODE_TEXEL, texel_index: 14'h3FFF, texel_color: 24'hFF_FFFF, default: '0});
    issue('{mode: MODE_TEXEL, texel_index: 14'h0000, texel_color: 24'h00_0000, default: '0});
    issue_column(1'b0, 16'h7FFF, 16'h8000, 22'h3F_FFFF, 11'd0, 12'd4, 16'd0);
    issue_rows(4);
    issue_rows(1);
    issue_column(1'b1, 16'h8000, 16'h7FFF, 22'd0, 11'd2047, 12'd2048, 16'hFFFF);
    issue_rows(2);
    issue_column(1'b1, 16'hFFFF, 16'h0001, 22'd123456, 11'd3, 12'd1, 16'd1);
    issue_rows(4);
    issue_column(1'b0, 16'hFFFB, 16'h0000, 22'd777, 11'd1, 12'd4, 16'd1);
    issue_rows(4);
    drain();

    write_reg(CFG_POS_X, 24'd0);
    write_reg(CFG_POS_Y, 24'h3F_FFFF);
    for (int p = 0; p < 8; p++) begin
      send_idle_pct = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      write_reg(CFG_SCREEN_H, 24'(heights[p]));
      write_reg(CFG_POS_X, 24'($urandom()));
      if (p > 0) write_reg(CFG_POS_Y, 24'($urandom()));
      write_reg(CFG_CEIL_COLOR, (p == 7) ? 24'd0 : 24'($urandom()));
      write_reg(CFG_FLOOR_COLOR, (p == 7) ? 24'hFF_FFFF : 24'($urandom()));
      if (p == 2) hold_req = ~hold_req;
      random_phase(lengths[p]);
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Note whether the word on the input was taken at this edge.
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
  end

  // Input driver: a new word goes out once the previous one was taken.
  always @(negedge clk) begin
    word_t w;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = send_q.pop_front();
        in_mode <= w.mode;
        in_texel_index <= w.texel_index;
        in_texel_color <= w.texel_color;
        in_side <= w.side;
        in_ray_dir_x <= w.ray_dir_x;
        in_ray_dir_y <= w.ray_dir_y;
        in_perp_dist <= w.perp_dist;
        in_draw_start <= w.draw_start;
        in_draw_end <= w.draw_end;
        in_line_height <= w.line_height;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    int hold_left;
    bit hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: each pixel word is compared against the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_expect_q.size() == 0) begin
        $error("pixel word with no prediction: row %0d", out_row);
        fail_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_pixel_color !== want.pixel_color) begin
          $error("pixel_color expected %h actual %h", want.pixel_color, out_pixel_color);
          fail_count++;
        end
        if (out_row !== want.row) begin
          $error("row expected %0d actual %0d", want.row, out_row);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
